// File: hw/rtl/bfr_pkg.sv
package bfr_pkg;

	localparam int COEF_FRAC_BITS = 13;
	localparam int CORDIC_STAGES  = 16;
	localparam int NUM_TAPS       = 3;

	localparam int FREQ_W = 18;
	localparam int FS_W   = 18;
	localparam int COEF_W = 16;
	localparam int ANG_W  = 32;
	localparam int MAG_W  = 24;
	localparam int PH_W   = 16;

	// sine/cosine are Q30 with headroom for the CORDIC overshoot
	localparam int CS_FRAC = 30;
	localparam int CS_W    = 34;
	localparam int PROD_W  = COEF_W + CS_W;
	localparam int SUM_W   = PROD_W + 2;
	localparam int RI_W    = SUM_W - (COEF_FRAC_BITS + 1);
	localparam int VW      = RI_W + 2;
	localparam int MD_W    = VW - 1;

	localparam logic signed [CS_W-1:0] CORDIC_K = CS_W'(652032874);
	localparam logic [MAG_W-1:0] MAG_MAX = '1;
	localparam int PHASE_HALF  = 23040;
	localparam int PHASE_SCALE = 46080;

	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 40;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;
	localparam logic [2:0] REG_B0 = 3'd0;
	localparam logic [2:0] REG_B1 = 3'd1;
	localparam logic [2:0] REG_B2 = 3'd2;
	localparam logic [2:0] REG_A0 = 3'd3;
	localparam logic [2:0] REG_A1 = 3'd4;
	localparam logic [2:0] REG_A2 = 3'd5;
	localparam logic [2:0] REG_FS = 3'd6;

	localparam logic signed [COEF_W-1:0] COEF_ONE = 16'sd8192;
	localparam logic [FS_W-1:0] FS_RST = 18'd48000;

	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic signed [CS_W-1:0] cs_t;
	typedef logic signed [RI_W-1:0] ri_t;

	typedef struct packed {
		logic signed [VW-1:0] mag;
		logic [ANG_W-1:0]     ang;
		logic                 zero;
	} vec_t;

	typedef struct packed {
		logic [MAG_W-1:0]       magnitude;
		logic signed [PH_W-1:0] phase_deg;
		logic                   denom_zero;
	} res_t;

	// atan(2^-i) as a fraction of a full turn, Q0.32
	function automatic logic [ANG_W-1:0] atan_turn(input int idx);
		logic [ANG_W-1:0] v;
		case (idx)
			0: v = 32'd536870912;
			1: v = 32'd316933406;
			2: v = 32'd167458907;
			3: v = 32'd85004756;
			4: v = 32'd42667331;
			5: v = 32'd21354465;
			6: v = 32'd10679838;
			7: v = 32'd5340245;
			8: v = 32'd2670163;
			9: v = 32'd1335087;
			10: v = 32'd667544;
			11: v = 32'd333772;
			12: v = 32'd166886;
			13: v = 32'd83443;
			14: v = 32'd41722;
			15: v = 32'd20861;
			16: v = 32'd10430;
			17: v = 32'd5215;
			18: v = 32'd2608;
			19: v = 32'd1304;
			20: v = 32'd652;
			21: v = 32'd326;
			22: v = 32'd163;
			23: v = 32'd81;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// File: hw/rtl/bfr_angle_div.sv
module bfr_angle_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic [bfr_pkg::FREQ_W-1:0] freq,
	input  logic [bfr_pkg::FS_W-1:0]   fs,
	output logic                       out_valid,
	output logic [bfr_pkg::ANG_W-1:0]  theta
);
	import bfr_pkg::*;

	// (f*2^32 + fs/2) / fs: low 32 quotient bits equal the rounded turn fraction of f mod fs
	localparam int ND_W = FREQ_W + ANG_W;

	logic              vld_s [0:ND_W];
	logic [ND_W-1:0]   num_s [0:ND_W];
	logic [FS_W-1:0]   rem_s [0:ND_W];
	logic [ANG_W-1:0]  quo_s [0:ND_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s[0] <= {freq, ANG_W'(fs >> 1)};
			rem_s[0] <= '0;
			quo_s[0] <= '0;
		end
	end

	for (genvar i = 0; i < ND_W; i++) begin : g_step
		logic [FS_W:0] r2;
		logic [FS_W:0] diff;
		logic          ge;

		assign r2   = {rem_s[i], num_s[i][ND_W-1]};
		assign diff = r2 - {1'b0, fs};
		assign ge   = r2 >= {1'b0, fs};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= ge ? diff[FS_W-1:0] : r2[FS_W-1:0];
				num_s[i+1] <= num_s[i] << 1;
				quo_s[i+1] <= {quo_s[i][ANG_W-2:0], ge};
			end
		end
	end

	assign out_valid = vld_s[ND_W];
	assign theta     = (fs == '0) ? '0 : quo_s[ND_W];

endmodule

// File: hw/rtl/bfr_rot_cordic.sv
module bfr_rot_cordic (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic [bfr_pkg::ANG_W-1:0] theta,
	output logic                      out_valid,
	output bfr_pkg::cs_t              cos_val,
	output bfr_pkg::cs_t              sin_val
);
	import bfr_pkg::*;

	localparam int N = CORDIC_STAGES;

	logic vld_s  [0:N];
	logic flip_s [0:N];
	cs_t  x_s    [0:N];
	cs_t  y_s    [0:N];
	cs_t  z_s    [0:N];
	logic vld_o_s;
	cs_t  cos_s;
	cs_t  sin_s;

	logic             flip;
	logic [ANG_W-1:0] th;

	// outside +-90 degrees: rotate by half a turn and negate at the end
	assign flip = theta[ANG_W-1] ^ theta[ANG_W-2];
	assign th   = {theta[ANG_W-1] ^ flip, theta[ANG_W-2:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flip_s[0] <= flip;
			x_s[0]    <= CORDIC_K;
			y_s[0]    <= '0;
			z_s[0]    <= CS_W'($signed(th));
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_iter
		localparam cs_t AT = $signed(CS_W'(atan_turn(i)));
		cs_t dx;
		cs_t dy;

		assign dx = x_s[i] >>> i;
		assign dy = y_s[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				flip_s[i+1] <= flip_s[i];
				if (!z_s[i][CS_W-1]) begin
					x_s[i+1] <= x_s[i] - dy;
					y_s[i+1] <= y_s[i] + dx;
					z_s[i+1] <= z_s[i] - AT;
				end else begin
					x_s[i+1] <= x_s[i] + dy;
					y_s[i+1] <= y_s[i] - dx;
					z_s[i+1] <= z_s[i] + AT;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o_s <= 1'b0;
		end else if (en) begin
			vld_o_s <= vld_s[N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_s <= flip_s[N] ? -x_s[N] : x_s[N];
			sin_s <= flip_s[N] ? -y_s[N] : y_s[N];
		end
	end

	assign out_valid = vld_o_s;
	assign cos_val   = cos_s;
	assign sin_val   = sin_s;

endmodule

// File: hw/rtl/bfr_poly.sv
module bfr_poly (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  bfr_pkg::coef_t taps [bfr_pkg::NUM_TAPS],
	input  bfr_pkg::cs_t   cos1,
	input  bfr_pkg::cs_t   sin1,
	input  bfr_pkg::cs_t   cos2,
	input  bfr_pkg::cs_t   sin2,
	output logic           out_valid,
	output bfr_pkg::ri_t   re,
	output bfr_pkg::ri_t   im
);
	import bfr_pkg::*;

	logic                    vld_s1;
	logic                    vld_s2;
	logic signed [PROD_W-1:0] pr0_s1;
	logic signed [PROD_W-1:0] pr1_s1;
	logic signed [PROD_W-1:0] pr2_s1;
	logic signed [PROD_W-1:0] pi1_s1;
	logic signed [PROD_W-1:0] pi2_s1;
	ri_t                      re_s2;
	ri_t                      im_s2;
	logic signed [SUM_W-1:0]  sr;
	logic signed [SUM_W-1:0]  si;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	// tap zero sits at angle zero: cos is exactly one, sin zero
	always_ff @(posedge clk) begin
		if (en) begin
			pr0_s1 <= PROD_W'(taps[0]) <<< CS_FRAC;
			pr1_s1 <= taps[1] * cos1;
			pr2_s1 <= taps[2] * cos2;
			pi1_s1 <= taps[1] * sin1;
			pi2_s1 <= taps[2] * sin2;
		end
	end

	assign sr = SUM_W'(pr0_s1) + SUM_W'(pr1_s1) + SUM_W'(pr2_s1);
	assign si = -(SUM_W'(pi1_s1) + SUM_W'(pi2_s1));

	always_ff @(posedge clk) begin
		if (en) begin
			re_s2 <= RI_W'(sr >>> (COEF_FRAC_BITS + 1));
			im_s2 <= RI_W'(si >>> (COEF_FRAC_BITS + 1));
		end
	end

	assign out_valid = vld_s2;
	assign re        = re_s2;
	assign im        = im_s2;

endmodule

// File: hw/rtl/bfr_vec_cordic.sv
module bfr_vec_cordic (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  bfr_pkg::ri_t  re,
	input  bfr_pkg::ri_t  im,
	output logic          out_valid,
	output bfr_pkg::vec_t res
);
	import bfr_pkg::*;

	localparam int N = CORDIC_STAGES;

	logic                 vld_s  [0:N];
	logic                 zero_s [0:N];
	logic signed [VW-1:0] x_s    [0:N];
	logic signed [VW-1:0] y_s    [0:N];
	logic [ANG_W-1:0]     a_s    [0:N];

	logic signed [VW-1:0] xe;
	logic signed [VW-1:0] ye;
	logic                 neg;

	assign xe  = VW'(re);
	assign ye  = VW'(im);
	assign neg = re[RI_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	// left half plane: mirror through the origin, start half a turn round
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (re == '0) && (im == '0);
			x_s[0]    <= neg ? -xe : xe;
			y_s[0]    <= neg ? -ye : ye;
			a_s[0]    <= {neg, (ANG_W-1)'(0)};
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_iter
		localparam logic [ANG_W-1:0] AT = atan_turn(i);
		logic signed [VW-1:0] dx;
		logic signed [VW-1:0] dy;
		logic                 ypos;

		assign dx   = y_s[i] >>> i;
		assign dy   = x_s[i] >>> i;
		assign ypos = !y_s[i][VW-1] && (y_s[i] != '0);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[i+1] <= zero_s[i];
				if (ypos) begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					a_s[i+1] <= a_s[i] + AT;
				end else begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					a_s[i+1] <= a_s[i] - AT;
				end
			end
		end
	end

	assign out_valid = vld_s[N];
	assign res.mag   = x_s[N];
	assign res.ang   = a_s[N];
	assign res.zero  = zero_s[N];

endmodule

// File: hw/rtl/bfr_result.sv
module bfr_result (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  bfr_pkg::vec_t num_v,
	input  bfr_pkg::vec_t den_v,
	output logic          out_valid,
	output bfr_pkg::res_t res
);
	import bfr_pkg::*;

	localparam int NUM_W = MD_W + 17;
	localparam int CMP_W = MD_W + MAG_W;
	localparam int REM_W = MD_W + 1;
	localparam int PPW   = ANG_W + 17;

	logic                   vld_s1;
	logic                   dz_s1;
	logic [MD_W-1:0]        md_s1;
	logic [NUM_W-1:0]       num_s1;
	logic [ANG_W-1:0]       diff_s1;

	logic                   vld_s2;
	logic                   dz_s2;
	logic                   sat_s2;
	logic [MD_W-1:0]        md_s2;
	logic [REM_W-1:0]       rem0_s2;
	logic [MAG_W-1:0]       lo_s2;
	logic signed [PPW-1:0]  prod_s2;

	logic                   vld_s  [0:MAG_W];
	logic                   dz_s   [0:MAG_W];
	logic                   sat_s  [0:MAG_W];
	logic [MD_W-1:0]        md_s   [0:MAG_W];
	logic [REM_W-1:0]       rem_s  [0:MAG_W];
	logic [MAG_W-1:0]       lo_s   [0:MAG_W];
	logic [MAG_W-1:0]       quo_s  [0:MAG_W];
	logic signed [PH_W-1:0] ph_s   [0:MAG_W];

	logic [MD_W-1:0]        mn;
	logic [ANG_W-1:0]       angn;
	logic signed [PPW-1:0]  rounded;
	logic signed [PPW-1:0]  pq;
	logic signed [PH_W-1:0] ph;

	// a zero numerator counts as magnitude zero at angle zero
	assign mn   = num_v.zero ? '0 : num_v.mag[MD_W-1:0];
	assign angn = num_v.zero ? '0 : num_v.ang;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s1   <= in_valid;
			vld_s2   <= vld_s1;
			vld_s[0] <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dz_s1   <= den_v.zero || den_v.mag[VW-1] || (den_v.mag == '0);
			md_s1   <= den_v.mag[MD_W-1:0];
			num_s1  <= NUM_W'({mn, 16'h0000}) + NUM_W'(den_v.mag[MD_W-1:0] >> 1);
			diff_s1 <= angn - den_v.ang;

			dz_s2   <= dz_s1;
			md_s2   <= md_s1;
			sat_s2  <= CMP_W'(num_s1) >= {md_s1, MAG_W'(0)};
			rem0_s2 <= REM_W'(num_s1 >> MAG_W);
			lo_s2   <= num_s1[MAG_W-1:0];
			prod_s2 <= PPW'($signed(diff_s1)) * PPW'(PHASE_SCALE);
		end
	end

	// round to nearest, then fold minus half a turn onto plus half a turn
	assign rounded = prod_s2 + (PPW'(1) <<< (ANG_W - 1));
	assign pq      = rounded >>> ANG_W;
	assign ph      = (pq <= -PHASE_HALF) ? PH_W'(PHASE_HALF) : pq[PH_W-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			dz_s[0]  <= dz_s2;
			sat_s[0] <= sat_s2;
			md_s[0]  <= md_s2;
			rem_s[0] <= rem0_s2;
			lo_s[0]  <= lo_s2;
			quo_s[0] <= '0;
			ph_s[0]  <= ph;
		end
	end

	// restoring division, one quotient bit per stage
	for (genvar i = 0; i < MAG_W; i++) begin : g_div
		logic [REM_W-1:0] r2;
		logic [REM_W-1:0] mdx;
		logic             ge;

		assign r2  = {rem_s[i][REM_W-2:0], lo_s[i][MAG_W-1]};
		assign mdx = REM_W'(md_s[i]);
		assign ge  = r2 >= mdx;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dz_s[i+1]  <= dz_s[i];
				sat_s[i+1] <= sat_s[i];
				md_s[i+1]  <= md_s[i];
				ph_s[i+1]  <= ph_s[i];
				rem_s[i+1] <= ge ? (r2 - mdx) : r2;
				lo_s[i+1]  <= lo_s[i] << 1;
				quo_s[i+1] <= {quo_s[i][MAG_W-2:0], ge};
			end
		end
	end

	assign out_valid      = vld_s[MAG_W];
	assign res.magnitude  = dz_s[MAG_W] ? '0 : (sat_s[MAG_W] ? MAG_MAX : quo_s[MAG_W]);
	assign res.phase_deg  = dz_s[MAG_W] ? '0 : ph_s[MAG_W];
	assign res.denom_zero = dz_s[MAG_W];

endmodule

// File: hw/rtl/biquad_frequency_response.sv
// Biquad frequency response: for each frequency request (Hz) returns |H| as unsigned Q8.16
// (saturating) and arg H in degrees, Q8.7 signed, in (-180, 180], for the second-order
// section held in the coefficient registers. A zero denominator sets denom_zero in tuser and
// zeroes both results. One request is taken every clock cycle while the skid register is empty;
// each result passes through the 50-stage angle divider (frequency over sample rate), two
// CORDIC pipelines of CORDIC_STAGES steps each, and the 24-stage magnitude divider.
// Coefficients and sample rate may only be written while no request is in flight.
module biquad_frequency_response (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [bfr_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // [17:0] freq_hz
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [bfr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,   // [23:0] magnitude, [39:24] phase_deg
	output logic [0:0]                      m_axis_tuser,   // [0] denom_zero
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [bfr_pkg::ADDR_W-1:0]      paddr,
	input  logic [bfr_pkg::DATA_W-1:0]      pwdata,
	output logic [bfr_pkg::DATA_W-1:0]      prdata,
	output logic                            pready
);
	import bfr_pkg::*;

	coef_t           coef_b_q [NUM_TAPS];
	coef_t           coef_a_q [NUM_TAPS];
	logic [FS_W-1:0] fs_q;
	logic [2:0]      reg_idx;

	logic             en;
	logic             ang_v;
	logic [ANG_W-1:0] theta;
	logic             r1_v;
	logic             r2_v;
	cs_t              cos1;
	cs_t              sin1;
	cs_t              cos2;
	cs_t              sin2;
	logic             pn_v;
	logic             pd_v;
	ri_t              n_re;
	ri_t              n_im;
	ri_t              d_re;
	ri_t              d_im;
	logic             vn_v;
	logic             vd_v;
	vec_t             vn;
	vec_t             vd;
	logic             res_v;
	res_t             res;

	logic             out_valid_q;
	logic             skid_full_q;
	res_t             out_q;
	res_t             skid_q;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_b_q[0] <= COEF_ONE;
			coef_b_q[1] <= '0;
			coef_b_q[2] <= '0;
			coef_a_q[0] <= COEF_ONE;
			coef_a_q[1] <= '0;
			coef_a_q[2] <= '0;
			fs_q        <= FS_RST;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_B0: coef_b_q[0] <= pwdata[COEF_W-1:0];
				REG_B1: coef_b_q[1] <= pwdata[COEF_W-1:0];
				REG_B2: coef_b_q[2] <= pwdata[COEF_W-1:0];
				REG_A0: coef_a_q[0] <= pwdata[COEF_W-1:0];
				REG_A1: coef_a_q[1] <= pwdata[COEF_W-1:0];
				REG_A2: coef_a_q[2] <= pwdata[COEF_W-1:0];
				REG_FS: fs_q        <= pwdata[FS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_B0: prdata = DATA_W'(unsigned'(coef_b_q[0]));
			REG_B1: prdata = DATA_W'(unsigned'(coef_b_q[1]));
			REG_B2: prdata = DATA_W'(unsigned'(coef_b_q[2]));
			REG_A0: prdata = DATA_W'(unsigned'(coef_a_q[0]));
			REG_A1: prdata = DATA_W'(unsigned'(coef_a_q[1]));
			REG_A2: prdata = DATA_W'(unsigned'(coef_a_q[2]));
			REG_FS: prdata = DATA_W'(fs_q);
			default: prdata = '0;
		endcase
	end

	// the whole pipeline moves unless the skid register is occupied
	assign en            = !skid_full_q;
	assign s_axis_tready = en;

	bfr_angle_div u_ang (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_axis_tvalid),
		.freq      (s_axis_tdata[FREQ_W-1:0]),
		.fs        (fs_q),
		.out_valid (ang_v),
		.theta     (theta)
	);

	bfr_rot_cordic u_rot1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (ang_v),
		.theta     (theta),
		.out_valid (r1_v),
		.cos_val   (cos1),
		.sin_val   (sin1)
	);

	bfr_rot_cordic u_rot2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (ang_v),
		.theta     ({theta[ANG_W-2:0], 1'b0}),
		.out_valid (r2_v),
		.cos_val   (cos2),
		.sin_val   (sin2)
	);

	bfr_poly u_poly_n (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (r1_v && r2_v),
		.taps      (coef_b_q),
		.cos1      (cos1),
		.sin1      (sin1),
		.cos2      (cos2),
		.sin2      (sin2),
		.out_valid (pn_v),
		.re        (n_re),
		.im        (n_im)
	);

	bfr_poly u_poly_d (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (r1_v && r2_v),
		.taps      (coef_a_q),
		.cos1      (cos1),
		.sin1      (sin1),
		.cos2      (cos2),
		.sin2      (sin2),
		.out_valid (pd_v),
		.re        (d_re),
		.im        (d_im)
	);

	bfr_vec_cordic u_vec_n (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (pn_v),
		.re        (n_re),
		.im        (n_im),
		.out_valid (vn_v),
		.res       (vn)
	);

	bfr_vec_cordic u_vec_d (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (pd_v),
		.re        (d_re),
		.im        (d_im),
		.out_valid (vd_v),
		.res       (vd)
	);

	bfr_result u_res (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vn_v && vd_v),
		.num_v     (vn),
		.den_v     (vd),
		.out_valid (res_v),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (en) begin
			if (res_v) begin
				if (!out_valid_q || m_axis_tready) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_full_q <= 1'b1;
				end
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end else if (m_axis_tready) begin
			skid_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (res_v) begin
				if (!out_valid_q || m_axis_tready) begin
					out_q <= res;
				end else begin
					skid_q <= res;
				end
			end
		end else if (m_axis_tready) begin
			out_q <= skid_q;
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = {out_q.phase_deg, out_q.magnitude};
	assign m_axis_tuser[0] = out_q.denom_zero;

endmodule

// File: hw/rtl/bfr_checker.sv
module bfr_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [bfr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input logic [0:0]                      m_axis_tuser
);
	import bfr_pkg::*;

	logic signed [PH_W-1:0] phase;

	assign phase = m_axis_tdata[MAG_W+PH_W-1:MAG_W];

	// a held result stays put until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// request side only closes once a result is waiting
	a_skid: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("request side stalled with no result pending");

	a_dz: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
		else $error("zero denominator with non-zero results");

	a_phase: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (phase > -PHASE_HALF) && (phase <= PHASE_HALF))
		else $error("phase outside half-open range");

	// stall on the request side follows a stalled result
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready))
		else $error("request side stalled without a result backing up");

endmodule

bind biquad_frequency_response bfr_checker u_bfr_checker (.*);
